### rtl/i2crc_pkg.sv
//------------------------------------------------------------------------------
// i2crc_pkg
// Shared types, constants and the CRC-8 byte step for the register CRC framer.
//------------------------------------------------------------------------------
`default_nettype none

package i2crc_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h1D;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_CRC_ENABLE     = 2'd1,
        REG_REGISTER_LIMIT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [6:0] device_address;
        logic       crc_enable;
        logic [8:0] register_limit;
    } t_cfg;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd0;
    localparam logic       CRC_ENABLE_RST     = 1'b0;
    localparam logic [8:0] REGISTER_LIMIT_RST = 9'd256;

    // One byte of an MSB-first CRC-8, polynomial 0x1D.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] byte_in);
        logic [7:0] c;
        c = crc_in ^ byte_in;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/i2crc_if.sv
//------------------------------------------------------------------------------
// i2crc_req_if / i2crc_rsp_if
// Valid/ready channels for access requests and framed results.
//------------------------------------------------------------------------------
`default_nettype none

interface i2crc_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] register_address;
    logic [7:0] data_byte;
    logic [7:0] received_crc;

    modport source (
        output valid, operation, register_address, data_byte, received_crc,
        input  ready
    );
    modport sink (
        input  valid, operation, register_address, data_byte, received_crc,
        output ready
    );
endinterface

interface i2crc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic [7:0] crc_out;
    logic       crc_appended;
    logic [1:0] status;

    modport source (
        output valid, data_out, crc_out, crc_appended, status,
        input  ready
    );
    modport sink (
        input  valid, data_out, crc_out, crc_appended, status,
        output ready
    );
endinterface

`default_nettype wire

### rtl/i2crc_cfg.sv
//------------------------------------------------------------------------------
// i2crc_cfg
// APB register file holding device address, CRC enable and register limit.
//------------------------------------------------------------------------------
`default_nettype none

module i2crc_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [i2crc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [i2crc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [i2crc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                             pready,
    output      i2crc_pkg::t_cfg                  o_cfg
);

    i2crc_pkg::t_cfg r_cfg;
    i2crc_pkg::t_cfg n_cfg;
    logic [1:0]      w_idx;
    logic            w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                i2crc_pkg::REG_DEVICE_ADDRESS: n_cfg.device_address = pwdata[6:0];
                i2crc_pkg::REG_CRC_ENABLE:     n_cfg.crc_enable     = pwdata[0];
                i2crc_pkg::REG_REGISTER_LIMIT: n_cfg.register_limit = pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= i2crc_pkg::DEVICE_ADDRESS_RST;
            r_cfg.crc_enable     <= i2crc_pkg::CRC_ENABLE_RST;
            r_cfg.register_limit <= i2crc_pkg::REGISTER_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            i2crc_pkg::REG_DEVICE_ADDRESS: prdata[6:0] = r_cfg.device_address;
            i2crc_pkg::REG_CRC_ENABLE:     prdata[0]   = r_cfg.crc_enable;
            i2crc_pkg::REG_REGISTER_LIMIT: prdata[8:0] = r_cfg.register_limit;
            default: ;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/i2crc_pipe.sv
//------------------------------------------------------------------------------
// i2crc_pipe
// Three-stage datapath: one CRC byte per stage, range check in the first stage.
//------------------------------------------------------------------------------
`default_nettype none

module i2crc_pipe (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire i2crc_pkg::t_cfg i_cfg,
    i2crc_req_if.sink            i_req,
    i2crc_rsp_if.source          o_rsp
);

    typedef struct packed {
        logic       operation;
        logic [7:0] register_address;
        logic [7:0] data_byte;
        logic [7:0] received_crc;
        logic [7:0] crc;
        logic       range_err;
        logic       crc_en;
    } t_stage;

    typedef struct packed {
        logic [7:0]         data_out;
        logic [7:0]         crc_out;
        logic               crc_appended;
        i2crc_pkg::t_status status;
    } t_result;

    logic    r_s1_valid, r_s2_valid, r_s3_valid;
    t_stage  r_s1, r_s2;
    t_result r_s3;
    t_stage  n_s1, n_s2;
    t_result n_s3;
    logic    w_s1_ready, w_s2_ready, w_s3_ready;
    logic    w_s1_load, w_s2_load, w_s3_load;
    logic [7:0] w_crc3;

    // A stage takes new data when it is empty or its content moves on.
    assign w_s3_ready = !r_s3_valid || o_rsp.ready;
    assign w_s2_ready = !r_s2_valid || w_s3_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign i_req.ready = w_s1_ready;

    assign w_s1_load = w_s1_ready;
    assign w_s2_load = w_s2_ready;
    assign w_s3_load = w_s3_ready;

    // Stage 1: first CRC byte is the device address with the R/W bit.
    always_comb begin
        n_s1.operation        = i_req.operation;
        n_s1.register_address = i_req.register_address;
        n_s1.data_byte        = i_req.data_byte;
        n_s1.received_crc     = i_req.received_crc;
        n_s1.crc              = i2crc_pkg::crc8_byte(i2crc_pkg::CRC_INIT,
                                    {i_cfg.device_address, ~i_req.operation});
        n_s1.range_err        = {1'b0, i_req.register_address} >= i_cfg.register_limit;
        n_s1.crc_en           = i_cfg.crc_enable;
    end

    // Stage 2: register address byte.
    always_comb begin
        n_s2     = r_s1;
        n_s2.crc = i2crc_pkg::crc8_byte(r_s1.crc, r_s1.register_address);
    end

    // Stage 3: data byte, then compare and format the result.
    assign w_crc3 = i2crc_pkg::crc8_byte(r_s2.crc, r_s2.data_byte);

    always_comb begin
        n_s3.data_out     = r_s2.data_byte;
        n_s3.crc_out      = '0;
        n_s3.crc_appended = 1'b0;
        n_s3.status       = i2crc_pkg::ST_OK;
        priority if (r_s2.range_err) begin
            n_s3.data_out = '0;
            n_s3.status   = i2crc_pkg::ST_RANGE;
        end else if (r_s2.crc_en) begin
            n_s3.crc_out      = w_crc3;
            n_s3.crc_appended = 1'b1;
            if (r_s2.operation == i2crc_pkg::OP_READ && w_crc3 != r_s2.received_crc) begin
                n_s3.status = i2crc_pkg::ST_MISMATCH;
            end
        end else begin
            n_s3.crc_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_load) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1 <= n_s1;
        end
        if (w_s2_load) begin
            r_s2 <= n_s2;
        end
        if (w_s3_load) begin
            r_s3 <= n_s3;
        end
    end

    assign o_rsp.valid        = r_s3_valid;
    assign o_rsp.data_out     = r_s3.data_out;
    assign o_rsp.crc_out      = r_s3.crc_out;
    assign o_rsp.crc_appended = r_s3.crc_appended;
    assign o_rsp.status       = r_s3.status;

endmodule

`default_nettype wire

### rtl/i2c_register_crc8_framer.sv
//------------------------------------------------------------------------------
// i2c_register_crc8_framer
// CRC-8 generation and checking for single-byte I2C register accesses.
//------------------------------------------------------------------------------
// The block takes one access request per clock while the output side does
// not stall, and returns one result for each, in order. There are three CRC
// byte stages (device address with R/W bit, register address, data byte),
// each of which holds one request; backpressure on the result channel stalls
// the stages from the back without losing or repeating a request. Registers
// are written over the APB port at byte addresses 0 (device address), 4 (CRC
// enable) and 8 (register limit), and must only change while no request is
// in flight.
`default_nettype none

module i2c_register_crc8_framer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [i2crc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [i2crc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [i2crc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                             pready,
    i2crc_req_if.sink                             i_req,
    i2crc_rsp_if.source                           o_rsp
);

    i2crc_pkg::t_cfg w_cfg;

    i2crc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    i2crc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
